[rtl/odo_pkg.sv]
// odo_pkg: shared constants, state encoding and arctangent table for the
// dead-reckoning odometry block. No dependencies; compiled before all other files.

package odo_pkg;

  // rotation and output scaling
  localparam int CORDIC_ITERATIONS      = 16;
  localparam int POSITION_FRACTION_BITS = 8;
  localparam int ATAN_ENTRIES           = 24;
  localparam int ROT_ITERS = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                               : CORDIC_ITERATIONS;
  localparam int ITER_W    = $clog2(ROT_ITERS);
  localparam int OUT_SHIFT = 30 - POSITION_FRACTION_BITS;

  // serial datapath: words travel as digits
  localparam int WORD_W      = 48;
  localparam int DIGIT_W     = 16;
  localparam int DIGITS      = WORD_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);

  // field widths
  localparam int DEG_W   = 16;
  localparam int DIST_W  = 16;
  localparam int STEP_W  = 17;
  localparam int HEAD_W  = 16;
  localparam int CLIFF_W = 4;
  localparam int POS_W   = 40;

  // gain compensation 0.60725... in Q2.30, kept positive with a zero sign bit
  localparam logic [30:0] GAIN_Q30 = 31'd652032874;

  // degree to binary angle: one long division of {deg + bias, 180} by 360
  localparam int          BIASED_W   = 17;
  localparam logic [16:0] DEG_BIAS   = 17'd33120;
  localparam logic [15:0] DEG_HALF   = 16'd180;
  localparam logic [9:0]  DEG_TURN   = 10'd360;
  localparam int          DIVD_W     = BIASED_W + HEAD_W;
  localparam int          DIV_CNT_W  = $clog2(DIVD_W);
  localparam int          REM_W      = 9;

  // configuration port
  localparam int         CFG_ADDR_W       = 3;
  localparam int         CFG_DATA_W       = 32;
  localparam logic [0:0] REG_ANGLE_OFFSET = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HEAD,
    ST_MUL,
    ST_ROT,
    ST_ACC,
    ST_SAT,
    ST_OUT
  } state_t;

  // arctangent of 2^-i in units of 2^-32 turn, as a full datapath word
  function automatic logic [WORD_W-1:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return {{(WORD_W-32){1'b0}}, v};
  endfunction

endpackage

[rtl/odo_in_if.sv]
// odo_in_if: sensor report channel (valid/ready plus report fields).
// Depends on odo_pkg for field widths.

interface odo_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [odo_pkg::DEG_W-1:0]    angle_deg;
  logic signed [odo_pkg::DIST_W-1:0]   distance_mm;
  logic        [odo_pkg::CLIFF_W-1:0]  cliff_bits;

  modport source (output valid, angle_deg, distance_mm, cliff_bits, input ready);
  modport sink   (input valid, angle_deg, distance_mm, cliff_bits, output ready);
endinterface

[rtl/odo_out_if.sv]
// odo_out_if: pose result channel (valid/ready plus pose fields).
// Depends on odo_pkg for field widths.

interface odo_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [odo_pkg::POS_W-1:0]   pose_x;
  logic signed [odo_pkg::POS_W-1:0]   pose_y;
  logic        [odo_pkg::HEAD_W-1:0]  heading;
  logic                               cliff_detected;

  modport source (output valid, pose_x, pose_y, heading, cliff_detected, input ready);
  modport sink   (input valid, pose_x, pose_y, heading, cliff_detected, output ready);
endinterface

[rtl/wheel_odometry_dead_reckoning.sv]
// From request accept, the result passes through the heading division (one quotient
// bit per cycle over 33 bits) and the rotation loop, which runs each of its iterations
// over three 16-bit digits through one serial adder per lane; a new request is accepted
// only once the previous result has been loaded into the output register.
// Reset (synchronous, active low) clears position, previous distance, heading offset
// and any pending result; nothing needs a clearing pass.
// Depends on odo_pkg, odo_in_if and odo_out_if.

module wheel_odometry_dead_reckoning (
  input  logic                               clk,
  input  logic                               rst_n,
  odo_in_if.sink                             in_chan,
  odo_out_if.source                          out_chan,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [odo_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [odo_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [odo_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  // arithmetic right shift of a word by one digit
  function automatic logic [odo_pkg::WORD_W-1:0] digit_shr(
      input logic [odo_pkg::WORD_W-1:0] w);
    return {{odo_pkg::DIGIT_W{w[odo_pkg::WORD_W-1]}},
            w[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
  endfunction

  // clamp a sum word to the signed position range
  function automatic logic [odo_pkg::WORD_W-1:0] pos_sat(
      input logic [odo_pkg::WORD_W-1:0] w);
    logic [odo_pkg::WORD_W-odo_pkg::POS_W:0] top;
    top = w[odo_pkg::WORD_W-1:odo_pkg::POS_W-1];
    if (top == {(odo_pkg::WORD_W-odo_pkg::POS_W+1){w[odo_pkg::WORD_W-1]}}) begin
      return w;
    end else if (w[odo_pkg::WORD_W-1]) begin
      return {{(odo_pkg::WORD_W-odo_pkg::POS_W+1){1'b1}},
              {(odo_pkg::POS_W-1){1'b0}}};
    end else begin
      return {{(odo_pkg::WORD_W-odo_pkg::POS_W+1){1'b0}},
              {(odo_pkg::POS_W-1){1'b1}}};
    end
  endfunction

  odo_pkg::state_t state_r, state_nxt;

  logic [odo_pkg::HEAD_W-1:0]      offset_r;
  logic [odo_pkg::DIST_W-1:0]      prev_r;
  logic [odo_pkg::STEP_W-1:0]      step_r;
  logic                            cliff_r;
  logic [odo_pkg::DIVD_W-1:0]      dv_r;
  logic [odo_pkg::REM_W-1:0]       rem_r;
  logic [odo_pkg::DIV_CNT_W-1:0]   dcnt_r;
  logic [odo_pkg::HEAD_W-1:0]      head_r;
  logic [odo_pkg::WORD_W-1:0]      src_x_r, src_y_r, src_z_r;
  logic [odo_pkg::WORD_W-1:0]      dst_x_r, dst_y_r, dst_z_r;
  logic [odo_pkg::WORD_W-1:0]      acc_x_r, acc_y_r;
  logic [odo_pkg::ITER_W-1:0]      it_r;
  logic [odo_pkg::DIGIT_CNT_W-1:0] dg_r;
  logic                            carry_x_r, carry_y_r, carry_z_r;
  logic                            out_valid_r;
  logic [odo_pkg::POS_W-1:0]       out_x_r, out_y_r;
  logic [odo_pkg::HEAD_W-1:0]      out_head_r;
  logic                            out_cliff_r;

  logic in_ready, in_acc, out_free, out_load, cfg_wr;
  logic last_digit, last_iter, div_last;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    if (cfg_paddr[odo_pkg::CFG_ADDR_W-1:2] == odo_pkg::REG_ANGLE_OFFSET) begin
      cfg_prdata = {{(odo_pkg::CFG_DATA_W-odo_pkg::HEAD_W){1'b0}}, offset_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // handshake
  assign in_acc   = in_chan.valid & in_ready;
  assign out_free = ~out_valid_r | out_chan.ready;

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.pose_x         = out_x_r;
  assign out_chan.pose_y         = out_y_r;
  assign out_chan.heading        = out_head_r;
  assign out_chan.cliff_detected = out_cliff_r;

  // sequencing conditions
  assign last_digit = (dg_r == odo_pkg::DIGIT_CNT_W'(odo_pkg::DIGITS - 1));
  assign last_iter  = (it_r == odo_pkg::ITER_W'(odo_pkg::ROT_ITERS - 1));
  assign div_last   = (dcnt_r == odo_pkg::DIV_CNT_W'(odo_pkg::DIVD_W - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      odo_pkg::ST_IDLE: if (in_acc) state_nxt = odo_pkg::ST_DIV;
      odo_pkg::ST_DIV:  if (div_last) state_nxt = odo_pkg::ST_HEAD;
      odo_pkg::ST_HEAD: state_nxt = odo_pkg::ST_MUL;
      odo_pkg::ST_MUL:  state_nxt = odo_pkg::ST_ROT;
      odo_pkg::ST_ROT:  if (last_digit && last_iter) state_nxt = odo_pkg::ST_ACC;
      odo_pkg::ST_ACC:  if (last_digit) state_nxt = odo_pkg::ST_SAT;
      odo_pkg::ST_SAT:  state_nxt = odo_pkg::ST_OUT;
      odo_pkg::ST_OUT:  if (out_free) state_nxt = odo_pkg::ST_IDLE;
      default:          state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      odo_pkg::ST_IDLE: in_ready = 1'b1;
      odo_pkg::ST_OUT:  out_load = out_free;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // heading division: one restoring step per cycle
  logic [odo_pkg::REM_W:0]   div_part, div_diff;
  logic                      div_ge;
  logic [odo_pkg::REM_W-1:0] rem_nxt;

  assign div_part = {rem_r, dv_r[odo_pkg::DIVD_W-1]};
  assign div_ge   = (div_part >= odo_pkg::DEG_TURN);
  assign div_diff = div_part - odo_pkg::DEG_TURN;
  assign rem_nxt  = div_ge ? div_diff[odo_pkg::REM_W-1:0] : div_part[odo_pkg::REM_W-1:0];

  // biased angle and distance step at request accept
  logic [odo_pkg::BIASED_W-1:0] biased_deg;
  logic [odo_pkg::STEP_W-1:0]   step_nxt;

  assign biased_deg = {in_chan.angle_deg[odo_pkg::DEG_W-1], in_chan.angle_deg}
                      + odo_pkg::DEG_BIAS;
  assign step_nxt   = {in_chan.distance_mm[odo_pkg::DIST_W-1], in_chan.distance_mm}
                      - {prev_r[odo_pkg::DIST_W-1], prev_r};

  // fold headings near half a turn, then scale the step by the gain
  logic                             fold;
  logic signed [odo_pkg::STEP_W-1:0] mstep;
  logic signed [odo_pkg::WORD_W-1:0] prod;
  logic [31:0]                      z_turn;

  assign fold   = head_r[odo_pkg::HEAD_W-1] ^ head_r[odo_pkg::HEAD_W-2];
  assign mstep  = fold ? -$signed(step_r) : $signed(step_r);
  assign prod   = mstep * $signed({1'b0, odo_pkg::GAIN_Q30});
  assign z_turn = {head_r[odo_pkg::HEAD_W-1] ^ fold, head_r[odo_pkg::HEAD_W-2:0],
                   {(32-odo_pkg::HEAD_W){1'b0}}};

  // serial lanes: x, y and angle, one digit per cycle
  logic                        is_acc, zneg;
  logic [odo_pkg::WORD_W-1:0]  atan_w;
  logic [odo_pkg::DIGIT_W-1:0] a_x, b_x, a_y, b_y, b_z, s_x, s_y, s_z;
  logic                        sub_x, sub_y, sub_z, cin_x, cin_y, cin_z;
  logic                        co_x, co_y, co_z, init_x, init_y;

  assign is_acc = (state_r == odo_pkg::ST_ACC);
  assign zneg   = src_z_r[odo_pkg::WORD_W-1];
  assign atan_w = odo_pkg::atan_turn(5'(it_r));

  assign a_x    = is_acc ? acc_x_r[odo_pkg::DIGIT_W-1:0] : src_x_r[odo_pkg::DIGIT_W-1:0];
  assign b_x    = is_acc ? src_x_r[odo_pkg::OUT_SHIFT +: odo_pkg::DIGIT_W]
                         : src_y_r[it_r +: odo_pkg::DIGIT_W];
  assign sub_x  = ~is_acc & ~zneg;
  assign init_x = is_acc ? src_x_r[odo_pkg::OUT_SHIFT-1] : sub_x;
  assign cin_x  = (dg_r == '0) ? init_x : carry_x_r;

  assign a_y    = is_acc ? acc_y_r[odo_pkg::DIGIT_W-1:0] : src_y_r[odo_pkg::DIGIT_W-1:0];
  assign b_y    = is_acc ? src_y_r[odo_pkg::OUT_SHIFT +: odo_pkg::DIGIT_W]
                         : src_x_r[it_r +: odo_pkg::DIGIT_W];
  assign sub_y  = ~is_acc & zneg;
  assign init_y = is_acc ? src_y_r[odo_pkg::OUT_SHIFT-1] : sub_y;
  assign cin_y  = (dg_r == '0) ? init_y : carry_y_r;

  assign b_z    = atan_w[dg_r * odo_pkg::DIGIT_W +: odo_pkg::DIGIT_W];
  assign sub_z  = ~zneg;
  assign cin_z  = (dg_r == '0) ? sub_z : carry_z_r;

  assign {co_x, s_x} = {1'b0, a_x} + {1'b0, b_x ^ {odo_pkg::DIGIT_W{sub_x}}}
                       + {{odo_pkg::DIGIT_W{1'b0}}, cin_x};
  assign {co_y, s_y} = {1'b0, a_y} + {1'b0, b_y ^ {odo_pkg::DIGIT_W{sub_y}}}
                       + {{odo_pkg::DIGIT_W{1'b0}}, cin_y};
  assign {co_z, s_z} = {1'b0, src_z_r[odo_pkg::DIGIT_W-1:0]}
                       + {1'b0, b_z ^ {odo_pkg::DIGIT_W{sub_z}}}
                       + {{odo_pkg::DIGIT_W{1'b0}}, cin_z};

  // control state, position and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odo_pkg::ST_IDLE;
      offset_r    <= '0;
      prev_r      <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      dcnt_r      <= '0;
      it_r        <= '0;
      dg_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[odo_pkg::CFG_ADDR_W-1:2] == odo_pkg::REG_ANGLE_OFFSET) begin
        offset_r <= cfg_pwdata[odo_pkg::HEAD_W-1:0];
      end
      if (in_acc) begin
        prev_r <= in_chan.distance_mm;
        dcnt_r <= '0;
      end
      if (state_r == odo_pkg::ST_DIV) begin
        dcnt_r <= dcnt_r + 1'b1;
      end
      if (state_r == odo_pkg::ST_MUL) begin
        it_r <= '0;
        dg_r <= '0;
      end
      if (state_r == odo_pkg::ST_ROT) begin
        dg_r <= last_digit ? '0 : dg_r + 1'b1;
        if (last_digit && !last_iter) begin
          it_r <= it_r + 1'b1;
        end
      end
      if (state_r == odo_pkg::ST_ACC) begin
        dg_r    <= last_digit ? '0 : dg_r + 1'b1;
        acc_x_r <= {s_x, acc_x_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
        acc_y_r <= {s_y, acc_y_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
      end
      if (state_r == odo_pkg::ST_SAT) begin
        acc_x_r <= pos_sat(acc_x_r);
        acc_y_r <= pos_sat(acc_y_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      step_r  <= step_nxt;
      cliff_r <= |in_chan.cliff_bits;
      dv_r    <= {biased_deg, odo_pkg::DEG_HALF};
      rem_r   <= '0;
    end
    unique case (state_r)
      odo_pkg::ST_DIV: begin
        dv_r  <= {dv_r[odo_pkg::DIVD_W-2:0], div_ge};
        rem_r <= rem_nxt;
      end
      odo_pkg::ST_HEAD: begin
        head_r <= offset_r + dv_r[odo_pkg::HEAD_W-1:0];
      end
      odo_pkg::ST_MUL: begin
        src_x_r <= prod;
        src_y_r <= '0;
        src_z_r <= {{(odo_pkg::WORD_W-32){z_turn[31]}}, z_turn};
      end
      odo_pkg::ST_ROT: begin
        carry_x_r <= co_x;
        carry_y_r <= co_y;
        carry_z_r <= co_z;
        if (last_digit) begin
          src_x_r <= {s_x, dst_x_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
          src_y_r <= {s_y, dst_y_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
          src_z_r <= {s_z, dst_z_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
        end else begin
          src_x_r <= digit_shr(src_x_r);
          src_y_r <= digit_shr(src_y_r);
          src_z_r <= digit_shr(src_z_r);
          dst_x_r <= {s_x, dst_x_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
          dst_y_r <= {s_y, dst_y_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
          dst_z_r <= {s_z, dst_z_r[odo_pkg::WORD_W-1:odo_pkg::DIGIT_W]};
        end
      end
      odo_pkg::ST_ACC: begin
        carry_x_r <= co_x;
        carry_y_r <= co_y;
        src_x_r   <= digit_shr(src_x_r);
        src_y_r   <= digit_shr(src_y_r);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x_r     <= acc_x_r[odo_pkg::POS_W-1:0];
      out_y_r     <= acc_y_r[odo_pkg::POS_W-1:0];
      out_head_r  <= head_r;
      out_cliff_r <= cliff_r;
    end
  end

endmodule

[rtl/odo_chk.sv]
// odo_chk: port-level assertions for the odometry block, bound to its top level.
// Depends on odo_pkg for field widths and on wheel_odometry_dead_reckoning.

module odo_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [odo_pkg::POS_W-1:0]         pose_x,
  input logic [odo_pkg::POS_W-1:0]         pose_y,
  input logic [odo_pkg::HEAD_W-1:0]        heading,
  input logic                              cliff_detected
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pose_x) && $stable(pose_y)
                                && $stable(heading) && $stable(cliff_detected))
    else $error("stalled result changed");

  // a request keeps the block busy for the following cycles
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("block ready again right after a request");

  // a new result only appears at the end of busy work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while block was idle");

  // busy work cannot finish while the previous result is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !in_ready |=> !in_ready)
    else $error("block went idle over a stalled result");

endmodule

bind wheel_odometry_dead_reckoning odo_chk u_odo_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .pose_x         (out_chan.pose_x),
  .pose_y         (out_chan.pose_y),
  .heading        (out_chan.heading),
  .cliff_detected (out_chan.cliff_detected)
);

[sim/wheel_odometry_dead_reckoning_tb.sv]
// Testbench for wheel_odometry_dead_reckoning: sensor reports in, poses out,
// predicted by an in-bench integrator and checked field by field.
// Depends on odo_pkg, odo_in_if, odo_out_if and the block itself.
`timescale 1ns / 1ps

module wheel_odometry_dead_reckoning_tb;

  // rotation setup mirrored from the block's parameters
  localparam int ROT_STEPS  = (odo_pkg::CORDIC_ITERATIONS > 24) ? 24
                                                               : odo_pkg::CORDIC_ITERATIONS;
  localparam int FRAC_SHIFT = 30 - odo_pkg::POSITION_FRACTION_BITS;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint POS_MAX = (longint'(1) <<< 39) - 1;
  localparam longint POS_MIN = -(longint'(1) <<< 39);

  // register map and run limits
  localparam int ADDR_ANGLE_OFFSET = 4 * odo_pkg::REG_ANGLE_OFFSET;
  localparam int ADDR_SPARE        = 4;
  localparam int SETTLE_CYCLES     = 100;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic signed [odo_pkg::POS_W-1:0] x;
    logic signed [odo_pkg::POS_W-1:0] y;
    logic [odo_pkg::HEAD_W-1:0]       heading;
    logic                             cliff;
  } pose_t;

  logic clk;
  logic rst_n;
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [odo_pkg::CFG_ADDR_W-1:0]    cfg_paddr;
  logic [odo_pkg::CFG_DATA_W-1:0]    cfg_pwdata;
  logic [odo_pkg::CFG_DATA_W-1:0]    cfg_prdata;
  logic                              cfg_pready;

  odo_in_if  in_chan ();
  odo_out_if out_chan ();

  wheel_odometry_dead_reckoning dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // integrator state, as the block should hold it
  longint                   track_x = 0;
  longint                   track_y = 0;
  logic signed [15:0]       last_distance = '0;
  logic [15:0]              heading_offset = '0;
  longint                   atan_steps [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  pose_t       expected_poses [$];
  pose_t       oldest_pose;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // idling controls
  bit          gaps_on = 1'b0;
  bit          stall_on = 1'b0;
  int          burst_left = 0;
  int          ready_hold = 0;

  // synthetic trajectory for the random part
  logic signed [15:0] walk_deg = '0;
  logic signed [15:0] walk_dist = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate to the 40-bit position range
  function automatic longint clamp40(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // mm * 2^30 down to position units, round half up
  function automatic longint round_to_pos(input longint v);
    if (FRAC_SHIFT == 0) return v;
    return (v + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
  endfunction

  // advance the pose by one sensor report and return the pose it should give
  function automatic pose_t integrate_report(input logic signed [15:0] deg,
                                             input logic signed [15:0] dist_mm,
                                             input logic [3:0] cliffs);
    longint      turn_deg;
    longint      step;
    longint      vx;
    longint      vy;
    longint      ang;
    longint      dx;
    longint      dy;
    logic [15:0] head;
    logic [31:0] phase32;
    int          i;
    pose_t       p;
    turn_deg = longint'(deg) % 360;
    if (turn_deg < 0) turn_deg += 360;
    head = heading_offset + 16'((turn_deg * 65536 + 180) / 360);
    step = longint'(dist_mm) - longint'(last_distance);
    last_distance = dist_mm;
    vx = step * CORDIC_GAIN;
    vy = 0;
    phase32 = {head, 16'h0000};
    // fold the back half turn onto the front one
    if (phase32[31:30] == 2'b01 || phase32[31:30] == 2'b10) begin
      vx = -vx;
      phase32 = phase32 + 32'h8000_0000;
    end
    ang = longint'($signed(phase32));
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = vx >>> i;
      dy = vy >>> i;
      if (ang >= 0) begin
        vx = vx - dy;
        vy = vy + dx;
        ang = ang - atan_steps[i];
      end else begin
        vx = vx + dy;
        vy = vy - dx;
        ang = ang + atan_steps[i];
      end
    end
    track_x = clamp40(track_x + round_to_pos(vx));
    track_y = clamp40(track_y + round_to_pos(vy));
    p.x = track_x[39:0];
    p.y = track_y[39:0];
    p.heading = head;
    p.cliff = |cliffs;
    return p;
  endfunction

  // result checker: compare every accepted pose with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_poses.size() == 0) begin
        $error("pose with no report pending: x %0d y %0d heading %0d",
               out_chan.pose_x, out_chan.pose_y, out_chan.heading);
        fail_count++;
      end else begin
        oldest_pose = expected_poses.pop_front();
        if (out_chan.pose_x !== oldest_pose.x) begin
          $error("pose_x: expected %0d, got %0d", oldest_pose.x, out_chan.pose_x);
          fail_count++;
        end
        if (out_chan.pose_y !== oldest_pose.y) begin
          $error("pose_y: expected %0d, got %0d", oldest_pose.y, out_chan.pose_y);
          fail_count++;
        end
        if (out_chan.heading !== oldest_pose.heading) begin
          $error("heading: expected %0d, got %0d", oldest_pose.heading, out_chan.heading);
          fail_count++;
        end
        if (out_chan.cliff_detected !== oldest_pose.cliff) begin
          $error("cliff_detected: expected %0d, got %0d", oldest_pose.cliff,
                 out_chan.cliff_detected);
          fail_count++;
        end
      end
    end
  end

  // receiver: alternating ready and stall stretches of random length when stalls are on, else always ready
  always @(posedge clk) begin
    if (!stall_on) begin
      out_chan.ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_chan.ready <= ~out_chan.ready;
      ready_hold <= out_chan.ready ? $urandom_range(0, 60) : $urandom_range(0, 12);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // send one sensor report, opening a new burst when due, after a random gap if gaps are on
  task automatic send_report(input logic signed [15:0] deg,
                             input logic signed [15:0] dist_mm,
                             input logic [3:0] cliffs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (gaps_on) begin
        gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 120);
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid       <= 1'b1;
    in_chan.angle_deg   <= deg;
    in_chan.distance_mm <= dist_mm;
    in_chan.cliff_bits  <= cliffs;
    do @(posedge clk); while (!in_chan.ready);
    expected_poses.push_back(integrate_report(deg, dist_mm, cliffs));
  endtask

  // stop sending and wait for every pending pose
  task automatic drain_poses();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (expected_poses.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [odo_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [odo_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_ANGLE_OFFSET) heading_offset = data[15:0];
  endtask

  task automatic cfg_read(input logic [odo_pkg::CFG_ADDR_W-1:0] addr,
                          output logic [odo_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // offset register must read back as the 16-bit value kept
  task automatic check_offset_readback();
    logic [odo_pkg::CFG_DATA_W-1:0] got;
    cfg_read(ADDR_ANGLE_OFFSET, got);
    if (got !== {16'h0000, heading_offset}) begin
      $error("angle_offset: expected %0d, got %0d", heading_offset, got);
      fail_count++;
    end
  endtask

  // field extremes, every quadrant, wraps of the degree count, cliff flags
  task automatic test_directed_reports();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    check_offset_readback();
    send_report(16'sd0, 16'sd0, 4'b0000);
    send_report(16'sd90, 16'sd1000, 4'b0001);
    send_report(16'sd180, 16'sd2000, 4'b0010);
    send_report(16'sd270, 16'sd3000, 4'b0100);
    send_report(16'sd359, 16'sd3500, 4'b1000);
    send_report(16'sd360, 16'sd4000, 4'b0000);
    send_report(-16'sd1, 16'sd3000, 4'b1111);
    send_report(-16'sd180, 16'sd2990, 4'b0000);
    send_report(-16'sd359, 16'sd2990, 4'b0110);
    send_report(16'sd32767, 16'sd32767, 4'b0000);
    // large distance jumps in both directions
    send_report(-16'sd32768, -16'sd32768, 4'b0101);
    send_report(16'sd45, 16'sd32767, 4'b1010);
    send_report(16'sd135, -16'sd32768, 4'b0000);
    send_report(16'sd225, 16'sd32767, 4'b0000);
    send_report(16'sd315, -16'sd32768, 4'b0011);
    send_report(16'sd1, 16'sd0, 4'b0000);
    send_report(16'sd89, 16'sd1, 4'b1100);
    send_report(16'sd91, -16'sd1, 4'b0000);
    send_report(16'sd269, 16'sd0, 4'b0000);
    drain_poses();
  endtask

  // offset at its extremes, upper write bits ignored, spare address ignored
  task automatic test_heading_offset();
    cfg_write(ADDR_ANGLE_OFFSET, 32'hA5A5_FFFF);
    check_offset_readback();
    send_report(16'sd0, 16'sd100, 4'b0000);
    send_report(16'sd1, 16'sd200, 4'b0000);
    send_report(16'sd180, 16'sd300, 4'b0001);
    drain_poses();
    cfg_write(ADDR_SPARE, 32'h0000_1234);
    check_offset_readback();
    send_report(16'sd90, 16'sd400, 4'b0000);
    drain_poses();
    cfg_write(ADDR_ANGLE_OFFSET, 32'h0000_8000);
    check_offset_readback();
    send_report(16'sd0, 16'sd500, 4'b0000);
    send_report(16'sd270, 16'sd600, 4'b1000);
    drain_poses();
    cfg_write(ADDR_ANGLE_OFFSET, 32'h0000_3FFF);
    send_report(16'sd0, 16'sd700, 4'b0000);
    send_report(16'sd90, 16'sd800, 4'b0000);
    drain_poses();
  endtask

  // random walk with noise and jumps, over several offsets and idling mixes
  task automatic test_random_track();
    logic [15:0] offsets [0:5];
    int          phase;
    int          n;
    int          pick;
    logic [3:0]  cliffs;
    offsets[0] = 16'h0000;
    offsets[1] = 16'hFFFF;
    offsets[2] = 16'($urandom);
    offsets[3] = 16'h8000;
    offsets[4] = 16'($urandom);
    offsets[5] = 16'($urandom);
    for (phase = 0; phase < 6; phase++) begin
      cfg_write(ADDR_ANGLE_OFFSET, {16'($urandom), offsets[phase]});
      check_offset_readback();
      gaps_on  = (phase % 3 != 0);
      stall_on = (phase != 0) && (phase != 2);
      for (n = 0; n < 125; n++) begin
        pick = $urandom_range(0, 9);
        cliffs = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'b0000;
        if (pick < 7) begin
          walk_deg  = walk_deg + 16'(int'($urandom_range(0, 40)) - 20);
          walk_dist = walk_dist + 16'(int'($urandom_range(0, 600)) - 300);
          send_report(walk_deg, walk_dist, cliffs);
        end else if (pick < 9) begin
          send_report(16'($urandom), 16'($urandom), 4'($urandom));
        end else begin
          walk_dist = walk_dist + 16'($urandom);
          send_report(walk_deg, walk_dist, cliffs);
        end
      end
      drain_poses();
    end
  endtask

  // back-to-back full-size steps along x in both senses
  task automatic test_full_size_steps();
    int guard;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    cfg_write(ADDR_ANGLE_OFFSET, 32'h0000_0000);
    send_report(16'sd0, -16'sd32768, 4'b0000);
    // forward at 0 degrees, then backward at 180 degrees: both move +x
    for (guard = 0; guard < 8; guard++) begin
      send_report(16'sd0, 16'sd32767, 4'b0000);
      send_report(16'sd180, -16'sd32768, 4'b0000);
    end
    send_report(16'sd180, 16'sd32767, 4'b0001);
    send_report(16'sd0, -16'sd32768, 4'b0000);
    drain_poses();
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.angle_deg   <= '0;
    in_chan.distance_mm <= '0;
    in_chan.cliff_bits  <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_reports();
    test_heading_offset();
    test_random_track();
    test_full_size_steps();

    // let any stray pose show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_poses.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
